// ===== hw/rtl/mcsw_pkg.sv =====
`default_nettype none

package mcsw_pkg;

  // channel set
  localparam int CHANNELS    = 16;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [15:0] MULT_RESET = 16'd5000;
  localparam logic [31:0] ABS_RESET  = 32'hFFFF_FFFF;

  // command modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_SCAN  = 2'd2;

  // register indexes
  localparam int          CFG_IDX_W = 1;
  localparam logic [0:0]  REG_MULT  = 1'b0;
  localparam logic [0:0]  REG_ABS   = 1'b1;
  localparam int          CFG_W     = 32;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  channel;
    logic [7:0]  call_kind;
    logic [31:0] average_time_us;
    logic [47:0] now_us;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  stuck_channel;
    logic [47:0] elapsed_us;
    logic [31:0] channel_average_us;
    logic [7:0]  stuck_kind;
    logic        newly_stuck;
    logic        last;
  } result_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcsw_front.sv =====
`default_nettype none

module mcsw_front
  import mcsw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire cmd_t        cmd,
  output logic             busy,
  output queue_head_t      head,
  input  wire logic        pop
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              keep;
  logic              push;

  // drop unused modes and out-of-range channels at the door
  always_comb begin
    case (cmd.mode)
      MODE_START, MODE_END: keep = (32'(cmd.channel) < CHANNELS);
      MODE_SCAN:            keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  assign busy = (count == QCNT_W'(QUEUE_DEPTH));
  assign push = start && !busy && keep;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd;
    end
  end

  // queue pointers and fill count
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];

endmodule

`default_nettype wire

// ===== hw/rtl/mcsw_back.sv =====
`default_nettype none

module mcsw_back
  import mcsw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire queue_head_t          head,
  output logic                      pop,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output result_t                   res,
  output logic                      res_valid
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]  state;

  // configuration
  logic [15:0] mult;
  logic [31:0] thr;

  // per-channel state
  logic        chan_busy    [CHANNELS];
  logic [47:0] start_time   [CHANNELS];
  logic [31:0] average_time [CHANNELS];
  logic        stuck_mark   [CHANNELS];
  logic [7:0]  kind_tag     [CHANNELS];

  // scan sequencer
  logic [CH_W-1:0]  idx;
  logic [CNT_W-1:0] cnt;
  logic [47:0]      scan_now;

  // read stage
  logic             s1_valid;
  logic             s1_busy;
  logic [CH_W-1:0]  s1_ch;
  logic [47:0]      s1_elapsed;
  logic [47:0]      s1_prod;
  logic [31:0]      s1_avg;
  logic [7:0]       s1_kind;
  logic             s1_mark;

  // pending result, held until the next hit or the end of the scan
  result_t          pend;
  logic             pend_v;
  result_t          res_word;

  logic [47:0]      prod;
  logic             rel_hit;
  logic             abs_hit;
  logic             hit;
  logic             emit;
  logic             emit_last;
  logic [CH_W-1:0]  cmd_ch;

  assign pop    = (state == ST_IDLE) && head.valid;
  assign cmd_ch = CH_W'(head.cmd.channel);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= MULT_RESET;
      thr  <= ABS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MULT: mult <= cfg_data[15:0];
        REG_ABS:  thr  <= cfg_data[31:0];
        default:  ;
      endcase
    end
  end

  // stuck decision on the read stage
  assign rel_hit = (s1_avg != 32'd0) && (mult != 16'd0) && (s1_elapsed >= s1_prod);
  assign abs_hit = (s1_elapsed >= {16'd0, thr});
  assign hit     = s1_valid && s1_busy && (cnt < CNT_W'(MAX_RESULTS)) && (rel_hit || abs_hit);

  assign emit      = (hit && pend_v) || ((state == ST_FLUSH) && pend_v);
  assign emit_last = (state == ST_FLUSH);

  assign prod = {16'd0, average_time[idx]} * {32'd0, mult};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s1_valid <= 1'b0;
      pend_v   <= 1'b0;
      idx      <= '0;
      cnt      <= '0;
    end else begin
      s1_valid <= (state == ST_SCAN);
      case (state)
        ST_IDLE: begin
          if (pop && (head.cmd.mode == MODE_SCAN)) begin
            state  <= ST_SCAN;
            idx    <= '0;
            cnt    <= '0;
            pend_v <= 1'b0;
          end
        end
        ST_SCAN: begin
          idx <= idx + 1'b1;
          if (idx == CH_W'(CHANNELS - 1)) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          state  <= ST_IDLE;
          pend_v <= 1'b0;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (hit) begin
        cnt    <= cnt + 1'b1;
        pend_v <= 1'b1;
      end
    end
  end

  // scan time and read stage
  always_ff @(posedge clk) begin
    if (pop) begin
      scan_now <= head.cmd.now_us;
    end
    s1_busy    <= chan_busy[idx];
    s1_ch      <= idx;
    s1_elapsed <= scan_now - start_time[idx];
    s1_prod    <= prod;
    s1_avg     <= average_time[idx];
    s1_kind    <= kind_tag[idx];
    s1_mark    <= stuck_mark[idx];
  end

  // pending result
  always_ff @(posedge clk) begin
    if (hit) begin
      pend.stuck_channel      <= 4'(s1_ch);
      pend.elapsed_us         <= s1_elapsed;
      pend.channel_average_us <= s1_avg;
      pend.stuck_kind         <= s1_kind;
      pend.newly_stuck        <= !s1_mark;
      pend.last               <= 1'b0;
    end
  end

  // channel state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_busy[i]    <= 1'b0;
        average_time[i] <= 32'd0;
        stuck_mark[i]   <= 1'b0;
      end
    end else if (pop && (head.cmd.mode == MODE_START)) begin
      chan_busy[cmd_ch]  <= 1'b1;
      stuck_mark[cmd_ch] <= 1'b0;
    end else if (pop && (head.cmd.mode == MODE_END)) begin
      chan_busy[cmd_ch]    <= 1'b0;
      average_time[cmd_ch] <= head.cmd.average_time_us;
      stuck_mark[cmd_ch]   <= 1'b0;
    end else if (hit) begin
      stuck_mark[s1_ch] <= 1'b1;
    end
  end

  // start time and call kind, valid once the channel has started
  always_ff @(posedge clk) begin
    if (pop && (head.cmd.mode == MODE_START)) begin
      start_time[cmd_ch] <= head.cmd.now_us;
      kind_tag[cmd_ch]   <= head.cmd.call_kind;
    end
  end

  // registered result word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= emit;
    end
  end

  // pending result with its end-of-scan mark
  always_comb begin
    res_word      = pend;
    res_word.last = emit_last;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_word;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_channel_stall_watchdog.sv =====
// A start or end word is applied in the cycle after it is taken when the
// two-word queue is empty and the back end idle; a scan holds the back end through
// its scan, wait and flush states, one channel read per cycle, which sets the rate.
// Its results come one per cycle at most, the last one carrying the last mark and
// registered out from the flush state; the receiver cannot stall.
// Reset clears the queue, busy flags, averages, stuck marks and sets the registers to defaults.
`default_nettype none

module multi_channel_stall_watchdog
  import mcsw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire cmd_t                 cmd,
  output logic                      busy,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output result_t                   res,
  output logic                      res_valid
);

  queue_head_t head;
  logic        pop;

  // accept and classify words
  mcsw_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .head  (head),
    .pop   (pop)
  );

  // channel state and scan engine
  mcsw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res),
    .res_valid (res_valid)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mcsw_checker.sv =====
`default_nettype none

module mcsw_checker
  import mcsw_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [CFG_W-1:0]     cfg_data,
  input wire result_t              res,
  input wire logic                 res_valid
);

  logic [31:0] thr_shadow;

  // track the absolute threshold from the write port
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_shadow <= ABS_RESET;
    end else if (cfg_we && (cfg_index == REG_ABS)) begin
      thr_shadow <= cfg_data[31:0];
    end
  end

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result strobe right after reset");

  // queue empty after reset
  a_reset_ready: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy right after reset");

  // the queue only fills behind a word taken in
  a_fill_cause: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy)
    else $error("busy without a word taken");

  // a channel with no average can only be stuck by the absolute rule
  a_abs_rule: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.channel_average_us == 32'd0))
      |-> (res.elapsed_us >= {16'd0, thr_shadow}))
    else $error("stuck result below absolute threshold");

endmodule

bind multi_channel_stall_watchdog mcsw_checker u_mcsw_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .res       (res),
  .res_valid (res_valid)
);

`default_nettype wire

// ===== test/multi_channel_stall_watchdog_check.sv =====
`timescale 1ns / 100ps

module multi_channel_stall_watchdog_check
  import mcsw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire cmd_t                 cmd,
  input  wire logic                 busy,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire result_t              res,
  input  wire logic                 res_valid,
  output int                        errors,
  output int                        reports_left
);

  // predicted watchdog registers and per-channel state
  logic [15:0] mult_reg;
  logic [31:0] abs_reg;
  logic        chan_busy    [CHANNELS];
  logic [47:0] chan_t0      [CHANNELS];
  logic [31:0] chan_avg     [CHANNELS];
  logic        chan_flagged [CHANNELS];
  logic [7:0]  chan_kind    [CHANNELS];

  // stuck reports still owed by the block, oldest first
  result_t stuck_reports_q[$];
  result_t oldest;

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // apply one accepted word; a scan queues its stuck reports
  task automatic take_word(input cmd_t w);
    result_t     held;
    bit          have;
    int          found;
    logic [47:0] elapsed;
    logic [47:0] bound;
    case (w.mode)
      MODE_START, MODE_END: begin
        if (int'(w.channel) < CHANNELS) begin
          chan_flagged[w.channel] = 1'b0;
          if (w.mode == MODE_START) begin
            chan_busy[w.channel] = 1'b1;
            chan_t0[w.channel]   = w.now_us;
            chan_kind[w.channel] = w.call_kind;
          end else begin
            chan_busy[w.channel] = 1'b0;
            chan_avg[w.channel]  = w.average_time_us;
          end
        end
      end
      MODE_SCAN: begin
        have  = 1'b0;
        found = 0;
        held  = '0;
        for (int c = 0; c < CHANNELS; c++) begin
          if (found < MAX_RESULTS && chan_busy[c]) begin
            elapsed = w.now_us - chan_t0[c];
            bound   = 48'(chan_avg[c]) * 48'(mult_reg);
            if ((chan_avg[c] != '0 && mult_reg != '0 && elapsed >= bound) ||
                elapsed >= 48'(abs_reg)) begin
              // hold each report back until we know whether it closes the scan
              if (have) stuck_reports_q = {stuck_reports_q, held};
              held.stuck_channel      = 4'(c);
              held.elapsed_us         = elapsed;
              held.channel_average_us = chan_avg[c];
              held.stuck_kind         = chan_kind[c];
              held.newly_stuck        = !chan_flagged[c];
              held.last               = 1'b0;
              chan_flagged[c] = 1'b1;
              have = 1'b1;
              found++;
            end
          end
        end
        if (have) begin
          held.last = 1'b1;
          stuck_reports_q = {stuck_reports_q, held};
        end
      end
      default: ;
    endcase
  endtask

  // compare reports, track register writes, predict accepted words
  always @(posedge clk) begin
    if (rst) begin
      mult_reg = MULT_RESET;
      abs_reg  = ABS_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_busy[c]    = 1'b0;
        chan_t0[c]      = '0;
        chan_avg[c]     = '0;
        chan_flagged[c] = 1'b0;
        chan_kind[c]    = '0;
      end
      stuck_reports_q.delete();
      errors = 0;
    end else begin
      if (res_valid) begin
        if (stuck_reports_q.size() == 0) begin
          $display("%0t: stuck report expected none, got channel %0d elapsed %0h",
                   $time, res.stuck_channel, res.elapsed_us);
          errors++;
        end else begin
          oldest = stuck_reports_q.pop_front();
          check_field("stuck_channel", 64'(oldest.stuck_channel), 64'(res.stuck_channel));
          check_field("elapsed_us", 64'(oldest.elapsed_us), 64'(res.elapsed_us));
          check_field("channel_average_us", 64'(oldest.channel_average_us),
                      64'(res.channel_average_us));
          check_field("stuck_kind", 64'(oldest.stuck_kind), 64'(res.stuck_kind));
          check_field("newly_stuck", 64'(oldest.newly_stuck), 64'(res.newly_stuck));
          check_field("last", 64'(oldest.last), 64'(res.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MULT: mult_reg = cfg_data[15:0];
          REG_ABS:  abs_reg  = cfg_data;
          default:  ;
        endcase
      end
      if (start && !busy) take_word(cmd);
    end
    reports_left = stuck_reports_q.size();
  end

endmodule

// ===== test/multi_channel_stall_watchdog_test.sv =====
`timescale 1ns / 100ps

module multi_channel_stall_watchdog_test;
  import mcsw_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         PHASES       = 6;
  localparam int         PHASE_WORDS  = 50;
  localparam int         DRAIN_CYCLES = 64;

  // register settings per random phase, extremes included
  localparam logic [15:0] MULT_PLAN [PHASES] = '{16'd5000, 16'd0, 16'd65535,
                                                  16'd1, 16'd3, 16'd0};
  localparam logic [31:0] ABS_PLAN  [PHASES] = '{32'hFFFF_FFFF, 32'd1000, 32'd0,
                                                  32'd500000, 32'hFFFF_FFFF, 32'd20000};

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  cmd_t                 cmd       = '0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MULT;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 busy;
  result_t              res;
  logic                 res_valid;
  int                   errors;
  int                   reports_left;
  logic [47:0]          tnow;

  multi_channel_stall_watchdog u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res),
    .res_valid (res_valid)
  );

  multi_channel_stall_watchdog_check u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .res          (res),
    .res_valid    (res_valid),
    .errors       (errors),
    .reports_left (reports_left)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("multi_channel_stall_watchdog_test: done, errors");
    $finish;
  end

  function automatic cmd_t mk(input logic [1:0] mode, input logic [3:0] ch,
                              input logic [7:0] kind, input logic [31:0] avg,
                              input logic [47:0] now);
    cmd_t w;
    w.mode            = mode;
    w.channel         = ch;
    w.call_kind       = kind;
    w.average_time_us = avg;
    w.now_us          = now;
    return w;
  endfunction

  // hand one word over, idling on random cycles in front of it if may_idle is set
  task automatic send_word(input cmd_t w, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // wait until every owed report is in and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (reports_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers, junk in the unused upper bits of the multiplier write
  task automatic write_regs(input logic [15:0] mult, input logic [31:0] abs_us);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MULT;
    cfg_data  <= {16'($urandom), mult};
    @(posedge clk);
    cfg_index <= REG_ABS;
    cfg_data  <= abs_us;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly forward-moving time with short call lengths, some jumps and noise
  task automatic make_random_word(output cmd_t w);
    int pick;
    int span;
    int step;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 9);
    step = $urandom_range(0, 99);
    w.channel   = 4'($urandom);
    w.call_kind = 8'($urandom);
    if (span == 0) w.average_time_us = '0;
    else if (span == 1) w.average_time_us = $urandom;
    else w.average_time_us = $urandom_range(1, 3000);
    if (step < 85) tnow = tnow + 48'($urandom_range(0, 4000));
    else if (step < 95) tnow = tnow + 48'($urandom);
    else tnow = {16'($urandom), 32'($urandom)};
    w.now_us = tnow;
    if (pick < 4) w.mode = MODE_UNUSED;
    else if (pick < 38) w.mode = MODE_START;
    else if (pick < 60) w.mode = MODE_END;
    else w.mode = MODE_SCAN;
  endtask

  // stimulus and verdict
  initial begin
    cmd_t w;
    int   counted;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty scan, unused mode, time extremes, end on an idle channel
    send_word(mk(MODE_SCAN, 4'd0, 8'h00, 32'd0, 48'd0), 1'b1);
    send_word(mk(MODE_UNUSED, 4'hF, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF), 1'b1);
    send_word(mk(MODE_START, 4'd0, 8'h00, 32'd0, 48'd0), 1'b1);
    send_word(mk(MODE_START, 4'd15, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF), 1'b1);
    send_word(mk(MODE_END, 4'd5, 8'h00, 32'hFFFF_FFFF, 48'd0), 1'b1);
    send_word(mk(MODE_START, 4'd5, 8'hA5, 32'd0, 48'd100), 1'b1);
    // absolute rule, including an elapsed time that wrapped
    send_word(mk(MODE_SCAN, 4'd0, 8'h00, 32'd0, 48'h1_0000_0000), 1'b1);
    // relative rule just below and exactly at average times multiplier
    send_word(mk(MODE_END, 4'd0, 8'h00, 32'd1, 48'h1_0000_0000), 1'b1);
    send_word(mk(MODE_START, 4'd0, 8'h3C, 32'd0, 48'h1_0000_0000), 1'b1);
    send_word(mk(MODE_SCAN, 4'd0, 8'h00, 32'd0, 48'h1_0000_1387), 1'b1);
    send_word(mk(MODE_SCAN, 4'd0, 8'h00, 32'd0, 48'h1_0000_1388), 1'b1);
    // every channel busy and stuck: a full scan of sixteen reports
    for (int ch = 1; ch < 15; ch++) begin
      if (ch != 5)
        send_word(mk(MODE_START, 4'(ch), 8'(ch * 17), 32'd0, 48'h1_0000_2000), 1'b1);
    end
    send_word(mk(MODE_SCAN, 4'd0, 8'h00, 32'd0, 48'h100_0000_0000), 1'b1);
    settle();

    // random phases, one register setting each; phase 3 runs back to back
    tnow = 48'h1_0000_3000;
    for (int p = 0; p < PHASES; p++) begin
      write_regs(MULT_PLAN[p], ABS_PLAN[p]);
      if (p == 4) tnow = 48'hFFFF_FFF0_0000;
      counted = 0;
      while (counted < PHASE_WORDS) begin
        make_random_word(w);
        send_word(w, p != 3);
        if (w.mode != MODE_UNUSED) counted++;
      end
      settle();
    end

    if (errors == 0 && reports_left == 0) begin
      $display("multi_channel_stall_watchdog_test: done, clean");
    end else begin
      $display("multi_channel_stall_watchdog_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mcsw_pkg.sv
hw/rtl/mcsw_front.sv
hw/rtl/mcsw_back.sv
hw/rtl/multi_channel_stall_watchdog.sv
hw/rtl/mcsw_checker.sv
test/multi_channel_stall_watchdog_check.sv
test/multi_channel_stall_watchdog_test.sv
